// ===== rtl/qidp_pkg.sv =====
package qidp_pkg;

    localparam int ID_SLOTS        = 128;
    localparam int MAX_PER_REQUEST = 16;

    // Identifiers are kept in rows of the used-map memory. ROW_BITS must divide ID_SLOTS.
    localparam int ROW_BITS = 8;
    localparam int ROWS     = ID_SLOTS / ROW_BITS;
    localparam int ROW_AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BIT_AW   = $clog2(ROW_BITS);
    localparam int IDX_W    = ROW_AW + BIT_AW;
    localparam int SPAN_W   = $clog2(ID_SLOTS + 1);
    localparam int POP_W    = $clog2(ROW_BITS + 1);

    localparam int ID_W    = 16;
    localparam int COUNT_W = 5;

    typedef enum logic [0:0] {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK           = 2'd0,
        STAT_FULL         = 2'd1,
        STAT_RANGE        = 2'd2,
        STAT_ALREADY_FREE = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        CFG_POOL_FIRST = 1'b0,
        CFG_POOL_LAST  = 1'b1
    } cfg_index_t;

    typedef struct packed {
        action_t              action;
        logic [COUNT_W-1:0]   count;
        logic [ID_W-1:0]      queue_id;
    } qidp_in_t;

    typedef struct packed {
        status_t              status;
        logic                 id_valid;
        logic [ID_W-1:0]      granted_id;
        logic                 last;
    } qidp_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FREE_RD,
        S_FREE_CHK,
        S_CNT_RD,
        S_CNT_ACC,
        S_CNT_CHK,
        S_GR_RD,
        S_GR_LOAD,
        S_GR_PICK,
        S_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic    load_in;
        logic    rd_en;
        logic    rd_free;
        logic    row_clr;
        logic    row_inc;
        logic    cnt_acc;
        logic    work_load;
        logic    grant;
        logic    wb_work;
        logic    wb_free;
        logic    emit;
        logic    status_load;
        status_t status_val;
    } dp_cmd_t;

    typedef struct packed {
        logic is_free;
        logic cnt_zero;
        logic cnt_over;
        logic free_in_range;
        logic rd_bit_set;
        logic row_last;
        logic pool_short;
        logic work_has_free;
        logic grant_last;
        logic slot_free;
    } dp_stat_t;

endpackage

// ===== rtl/qidp_ctrl.sv =====
module qidp_ctrl
    import qidp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.is_free)
                begin
                    state_next = stat.free_in_range ? S_FREE_RD : S_EMIT;
                end
                else if (stat.cnt_zero || stat.cnt_over)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_CNT_RD;
                end
            end
            S_FREE_RD:
            begin
                state_next = S_FREE_CHK;
            end
            S_FREE_CHK:
            begin
                state_next = S_EMIT;
            end
            S_CNT_RD:
            begin
                state_next = S_CNT_ACC;
            end
            S_CNT_ACC:
            begin
                state_next = stat.row_last ? S_CNT_CHK : S_CNT_RD;
            end
            S_CNT_CHK:
            begin
                state_next = stat.pool_short ? S_EMIT : S_GR_RD;
            end
            S_GR_RD:
            begin
                state_next = S_GR_LOAD;
            end
            S_GR_LOAD:
            begin
                state_next = S_GR_PICK;
            end
            S_GR_PICK:
            begin
                if (!stat.work_has_free)
                begin
                    state_next = S_GR_RD;
                end
                else if (stat.slot_free && stat.grant_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (stat.slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            S_DECODE:
            begin
                if (stat.is_free)
                begin
                    if (!stat.free_in_range)
                    begin
                        cmd.status_load = 1'b1;
                        cmd.status_val  = STAT_RANGE;
                    end
                end
                else if (stat.cnt_zero)
                begin
                    cmd.status_load = 1'b1;
                    cmd.status_val  = STAT_OK;
                end
                else if (stat.cnt_over)
                begin
                    cmd.status_load = 1'b1;
                    cmd.status_val  = STAT_RANGE;
                end
                else
                begin
                    cmd.row_clr = 1'b1;
                end
            end
            S_FREE_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_free = 1'b1;
            end
            S_FREE_CHK:
            begin
                cmd.status_load = 1'b1;
                if (stat.rd_bit_set)
                begin
                    cmd.wb_free    = 1'b1;
                    cmd.status_val = STAT_OK;
                end
                else
                begin
                    cmd.status_val = STAT_ALREADY_FREE;
                end
            end
            S_CNT_RD:
            begin
                cmd.rd_en = 1'b1;
            end
            S_CNT_ACC:
            begin
                cmd.cnt_acc = 1'b1;
                cmd.row_inc = !stat.row_last;
            end
            S_CNT_CHK:
            begin
                if (stat.pool_short)
                begin
                    cmd.status_load = 1'b1;
                    cmd.status_val  = STAT_FULL;
                end
                else
                begin
                    cmd.row_clr = 1'b1;
                end
            end
            S_GR_RD:
            begin
                cmd.rd_en = 1'b1;
            end
            S_GR_LOAD:
            begin
                cmd.work_load = 1'b1;
            end
            S_GR_PICK:
            begin
                if (!stat.work_has_free)
                begin
                    cmd.wb_work = 1'b1;
                    cmd.row_inc = 1'b1;
                end
                else if (stat.slot_free)
                begin
                    cmd.grant   = 1'b1;
                    cmd.wb_work = stat.grant_last;
                end
            end
            S_EMIT:
            begin
                cmd.emit = stat.slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/qidp_dp.sv =====
module qidp_dp
    import qidp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    input  qidp_in_t          in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output qidp_out_t         out_item,
    input  logic              cfg_valid,
    input  logic [0:0]        cfg_index,
    input  logic [ID_W-1:0]   cfg_data
);

    logic [ID_W-1:0]     pool_first_reg;
    logic [ID_W-1:0]     pool_last_reg;
    qidp_in_t            in_reg;
    status_t             res_status_reg;
    logic [ROW_AW-1:0]   row_reg;
    logic [COUNT_W-1:0]  got_reg;
    logic [SPAN_W-1:0]   freec_reg;
    logic [ROW_BITS-1:0] work_reg;
    logic [ROW_BITS-1:0] rd_data_reg;
    logic [ROWS-1:0]     row_valid_reg;
    logic [ROW_BITS-1:0] mem [ROWS];
    logic                out_valid_reg;
    qidp_out_t           out_item_reg;

    logic [ID_W-1:0]     span_diff;
    logic [SPAN_W-1:0]   span_n;
    logic [ID_W-1:0]     free_off;
    logic [ROW_AW-1:0]   free_row;
    logic [BIT_AW-1:0]   free_bit;
    logic [ROW_BITS-1:0] free_onehot;
    logic [ROW_BITS-1:0] row_mask;
    logic [ROW_BITS-1:0] rd_free_bits;
    logic [ROW_BITS-1:0] work_free_bits;
    logic [ROW_BITS-1:0] pick_onehot;
    logic [BIT_AW-1:0]   pick_idx;
    logic [POP_W-1:0]    row_pop;
    logic [ROW_AW-1:0]   rd_addr;
    logic                wr_en;
    logic [ROW_AW-1:0]   wr_addr;
    logic [ROW_BITS-1:0] wr_data;
    logic                slot_free;
    logic [COUNT_W-1:0]  got_inc;

    assign span_diff = pool_last_reg - pool_first_reg;

    always_comb
    begin
        if (pool_last_reg < pool_first_reg)
        begin
            span_n = '0;
        end
        else if (span_diff >= ID_W'(ID_SLOTS - 1))
        begin
            span_n = SPAN_W'(ID_SLOTS);
        end
        else
        begin
            span_n = SPAN_W'(span_diff) + SPAN_W'(1);
        end
    end

    assign free_off    = in_reg.queue_id - pool_first_reg;
    assign free_row    = ROW_AW'(free_off >> BIT_AW);
    assign free_bit    = free_off[BIT_AW-1:0];
    assign free_onehot = ROW_BITS'(1) << free_bit;

    always_comb
    begin
        for (int j = 0; j < ROW_BITS; j++)
        begin
            row_mask[j] = SPAN_W'({row_reg, BIT_AW'(j)}) < span_n;
        end
    end

    assign rd_free_bits   = ~rd_data_reg & row_mask;
    assign work_free_bits = ~work_reg & row_mask;
    assign pick_onehot    = work_free_bits & (~work_free_bits + ROW_BITS'(1));

    always_comb
    begin
        pick_idx = '0;
        for (int j = ROW_BITS - 1; j >= 0; j--)
        begin
            if (work_free_bits[j])
            begin
                pick_idx = BIT_AW'(j);
            end
        end
    end

    always_comb
    begin
        row_pop = '0;
        for (int j = 0; j < ROW_BITS; j++)
        begin
            row_pop = row_pop + POP_W'(rd_free_bits[j]);
        end
    end

    assign slot_free = !out_valid_reg || out_ready;
    assign got_inc   = got_reg + COUNT_W'(1);

    assign rd_addr = cmd.rd_free ? free_row : row_reg;
    assign wr_en   = cmd.wb_free || cmd.wb_work;
    assign wr_addr = cmd.wb_free ? free_row : row_reg;
    assign wr_data = cmd.wb_free ? (rd_data_reg & ~free_onehot)
                                 : (work_reg | (cmd.grant ? pick_onehot : '0));

    always_comb
    begin
        stat.is_free       = (in_reg.action == ACT_FREE);
        stat.cnt_zero      = (in_reg.count == '0);
        stat.cnt_over      = (int'(in_reg.count) > MAX_PER_REQUEST);
        stat.free_in_range = (in_reg.queue_id >= pool_first_reg)
                             && (free_off < ID_W'(span_n));
        stat.rd_bit_set    = rd_data_reg[free_bit];
        stat.row_last      = (row_reg == ROW_AW'(ROWS - 1));
        stat.pool_short    = (freec_reg < SPAN_W'(in_reg.count))
                             || (int'(in_reg.count) > ID_SLOTS);
        stat.work_has_free = (work_free_bits != '0);
        stat.grant_last    = (got_inc == in_reg.count);
        stat.slot_free     = slot_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_first_reg <= ID_W'(1);
            pool_last_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_POOL_FIRST: pool_first_reg <= cfg_data;
                CFG_POOL_LAST:  pool_last_reg  <= cfg_data;
                default:        pool_first_reg <= pool_first_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_reg <= in_item;
        end
        if (cmd.status_load)
        begin
            res_status_reg <= cmd.status_val;
        end
        if (cmd.row_clr)
        begin
            row_reg   <= '0;
            got_reg   <= '0;
            freec_reg <= '0;
        end
        else
        begin
            if (cmd.row_inc)
            begin
                row_reg <= row_reg + ROW_AW'(1);
            end
            if (cmd.cnt_acc)
            begin
                freec_reg <= freec_reg + SPAN_W'(row_pop);
            end
            if (cmd.grant)
            begin
                got_reg <= got_inc;
            end
        end
        if (cmd.work_load)
        begin
            work_reg <= rd_data_reg;
        end
        else if (cmd.grant)
        begin
            work_reg <= work_reg | pick_onehot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= row_valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (wr_en)
        begin
            row_valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.grant || cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.grant)
        begin
            out_item_reg.status     <= STAT_OK;
            out_item_reg.id_valid   <= 1'b1;
            out_item_reg.granted_id <= pool_first_reg + ID_W'({row_reg, pick_idx});
            out_item_reg.last       <= stat.grant_last;
        end
        else if (cmd.emit)
        begin
            out_item_reg.status     <= res_status_reg;
            out_item_reg.id_valid   <= 1'b0;
            out_item_reg.granted_id <= '0;
            out_item_reg.last       <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.grant || cmd.emit) |-> (!out_valid_reg || out_ready))
        else $error("Result loaded while the output register is still full.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wb_free && cmd.wb_work))
        else $error("Two used-map writes requested in one cycle.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.grant |-> (work_free_bits != '0) && $onehot(pick_onehot))
        else $error("Grant issued without a free identifier in the row.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_item_reg.id_valid) |-> out_item_reg.last)
        else $error("Result without an identifier is not flagged last.");
`endif

endmodule

// ===== rtl/queue_id_pool_allocator.sv =====
// Queue identifier pool allocator. A used-map memory, cleared at reset, covers the identifiers
// from pool_first to pool_last, at most ID_SLOTS of them. An allocate item for N identifiers
// either grants the N lowest free ones, one result per identifier in ascending order with the
// final one flagged last, or returns a single pool-full result and changes nothing; N of zero
// or over MAX_PER_REQUEST gives one OK or range result with no identifier. A free item returns
// one result. Items are handled one at a time. The used-map is kept in rows of ROW_BITS bits
// with one read port, so an allocate first reads every row to count its free identifiers, then
// reads rows again from the first and grants their free identifiers lowest first. A free reads
// and checks the row of its identifier. Results leave through a one-item output register,
// so the next item is taken while the last result still waits, and a stalled output pauses the
// granting. The pool registers may be written only while the block is idle; they do not clear
// the used-map, whose bits stay relative to pool_first.
module queue_id_pool_allocator
    import qidp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  qidp_in_t          in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output qidp_out_t         out_item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [0:0]        cfg_index,
    input  logic [ID_W-1:0]   cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    qidp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    qidp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// ===== bench/tb_queue_id_pool_allocator.sv =====
`timescale 1ns / 1ps

module tb_queue_id_pool_allocator;
    import qidp_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 3000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    qidp_in_t          in_item = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    qidp_out_t         out_item;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [0:0]        cfg_index = '0;
    logic [ID_W-1:0]   cfg_data = '0;

    qidp_in_t          pool_requests[$];
    qidp_out_t         pool_replies_due[$];

    logic [ID_SLOTS-1:0]  shadow_used = '0;
    logic [ID_W-1:0]      shadow_first = 16'd1;
    logic [ID_W-1:0]      shadow_last = 16'd0;

    bit                no_idle = 1'b0;
    bit                hold_req = 1'b0;
    bit                hold_done = 1'b0;
    int                hold_left = 0;
    int                send_gap = 0;
    int                recv_stall = 0;
    int                quiet_cycles = 0;
    int                mismatches = 0;

    queue_id_pool_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic int pool_span();
        int n;
        if (shadow_last < shadow_first)
            return 0;
        n = int'(shadow_last) - int'(shadow_first) + 1;
        return (n > ID_SLOTS) ? ID_SLOTS : n;
    endfunction

    function automatic void predict_pool_reply(qidp_in_t req);
        int        n;
        int        off;
        int        free_bits;
        int        got;
        qidp_out_t r;
        n = pool_span();
        r.status     = STAT_OK;
        r.id_valid   = 1'b0;
        r.granted_id = '0;
        r.last       = 1'b1;
        if (req.action == ACT_FREE)
        begin
            off = int'(req.queue_id) - int'(shadow_first);
            if (off < 0 || off >= n)
                r.status = STAT_RANGE;
            else if (!shadow_used[off])
                r.status = STAT_ALREADY_FREE;
            else
                shadow_used[off] = 1'b0;
            pool_replies_due.push_back(r);
            return;
        end
        if (req.count > MAX_PER_REQUEST)
            r.status = STAT_RANGE;
        if (req.count == 0 || req.count > MAX_PER_REQUEST)
        begin
            pool_replies_due.push_back(r);
            return;
        end
        free_bits = 0;
        for (int b = 0; b < n; b++)
            if (!shadow_used[b])
                free_bits++;
        if (free_bits < int'(req.count))
        begin
            r.status = STAT_FULL;
            pool_replies_due.push_back(r);
            return;
        end
        got = 0;
        for (int b = 0; b < n && got < int'(req.count); b++)
        begin
            if (!shadow_used[b])
            begin
                shadow_used[b] = 1'b1;
                got++;
                r.id_valid   = 1'b1;
                r.granted_id = shadow_first + ID_W'(b);
                r.last       = (got == int'(req.count));
                pool_replies_due.push_back(r);
            end
        end
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task automatic check_result(input qidp_out_t got);
        qidp_out_t want;
        if (pool_replies_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result status=%0d id_valid=%0d id=%0d last=%0d",
                got.status, got.id_valid, got.granted_id, got.last));
            return;
        end
        want = pool_replies_due.pop_front();
        if (got.status !== want.status || got.id_valid !== want.id_valid ||
            got.granted_id !== want.granted_id || got.last !== want.last)
            report_mismatch($sformatf(
                "status %0d/%0d id_valid %0d/%0d id %0d/%0d last %0d/%0d (got/want)",
                got.status, want.status, got.id_valid, want.id_valid,
                got.granted_id, want.granted_id, got.last, want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_pool_reply(in_item);
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pool_requests.size() != 0)
                begin
                    in_item  <= pool_requests.pop_front();
                    in_valid <= 1'b1;
                    send_gap <= no_idle ? 0 : $urandom_range(0, 13);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_req && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        int stall;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            recv_stall <= 0;
        end
        else
        begin
            stall = recv_stall;
            if (out_valid && out_ready)
            begin
                check_result(out_item);
                stall = no_idle ? 0 : $urandom_range(0, 13);
            end
            else if (out_valid && stall != 0)
                stall--;
            recv_stall <= stall;
            out_ready  <= (hold_left == 0) && (stall == 0);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("queue_id_pool_allocator test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic push_alloc(input int n);
        qidp_in_t req;
        req.action   = ACT_ALLOC;
        req.count    = COUNT_W'(n);
        req.queue_id = ID_W'($urandom_range(0, 65535));
        pool_requests.push_back(req);
    endtask

    task automatic push_free(input int id);
        qidp_in_t req;
        req.action   = ACT_FREE;
        req.count    = COUNT_W'($urandom_range(0, 31));
        req.queue_id = ID_W'(id);
        pool_requests.push_back(req);
    endtask

    task automatic push_random();
        int sel;
        sel = $urandom_range(0, 19);
        if ($urandom_range(0, 99) < 55)
        begin
            if (sel < 14)
                push_free(int'(shadow_first) + $urandom_range(0, pool_span() + 1));
            else
                push_free($urandom_range(0, 65535));
        end
        else if (sel == 0)
            push_alloc(0);
        else if (sel == 1)
            push_alloc($urandom_range(17, 31));
        else if (sel < 5)
            push_alloc($urandom_range(5, 16));
        else
            push_alloc($urandom_range(1, 4));
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pool_requests.size() != 0 || in_valid || pool_replies_due.size() != 0);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_pool_reg(input cfg_index_t idx, input logic [ID_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_POOL_FIRST)
            shadow_first = val;
        else
            shadow_last = val;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int first, input int last, input int items, input bit steady);
        wait_idle();
        write_pool_reg(CFG_POOL_FIRST, ID_W'(first));
        write_pool_reg(CFG_POOL_LAST, ID_W'(last));
        @(negedge clk);
        no_idle = steady;
        repeat (items) push_random();
    endtask

    initial
    begin
        int first;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The pool is empty out of reset.
        push_alloc(0);
        push_alloc(1);
        push_free(0);
        push_free(1);
        push_free(65535);

        wait_idle();
        write_pool_reg(CFG_POOL_FIRST, 16'd0);
        write_pool_reg(CFG_POOL_LAST, 16'hFFFF);
        @(negedge clk);
        push_alloc(16);
        push_alloc(17);
        push_alloc(31);
        push_free(15);
        push_free(15);
        push_free(127);
        push_free(128);
        push_free(16'h8000);
        repeat (7) push_alloc(16);
        push_alloc(2);
        push_alloc(1);
        push_alloc(0);

        run_phase(65530, 65535, 16, 1'b0);
        run_phase(0, 7, 18, 1'b1);
        run_phase(65535, 65535, 12, 1'b0);
        run_phase(200, 199, 8, 1'b0);

        // The receiver stops for a long stretch while the sender keeps offering items.
        wait_idle();
        write_pool_reg(CFG_POOL_FIRST, 16'd0);
        write_pool_reg(CFG_POOL_LAST, 16'd127);
        @(negedge clk);
        no_idle = 1'b1;
        for (int i = 0; i < 8; i++)
            push_free(i);
        push_alloc(8);
        push_alloc(16);
        repeat (10) push_random();
        hold_req = 1'b1;

        first = $urandom_range(0, 65535 - 200);
        run_phase(first, first + $urandom_range(0, 150), 12, 1'b0);
        run_phase(0, 65535, 12, 1'b0);

        wait_idle();
        repeat (100) @(negedge clk);
        if (pool_replies_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pool_replies_due.size()));
        if (mismatches == 0)
            $display("queue_id_pool_allocator test passed");
        else
            $display("queue_id_pool_allocator test failed");
        $finish;
    end

endmodule
